@@ hdl/dqp_pkg.sv @@
// shared types and constants for the dns question parser
// no dependencies; imported by every module under hdl
package dqp_pkg;

  // size of the packet buffer; a question may use at most BUFFER_BYTES-1 bytes
  localparam int BUFFER_BYTES = 2048;
  localparam int CNT_W        = $clog2(BUFFER_BYTES);

  localparam int AVAIL_W  = 11;
  localparam int OFFSET_W = 11;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [7:0]            name_char;
    logic [15:0]           qtype;
    logic [15:0]           qclass;
    logic [OFFSET_W-1:0]   end_offset;
  } result_t;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                first;
    logic [AVAIL_W-1:0]  avail_len;
  } item_t;

endpackage

@@ hdl/dns_question_parser.sv @@
// top level of the dns question parser
// depends on dqp_pkg, dqp_in_stage, dqp_parse, dqp_out_stage

// Decodes a DNS question section fed one byte per word. Each length-prefixed
// label comes out as one name character per result word, with a dot word
// issued on the length byte of every label after the first. After the zero
// terminator the next four bytes give query type and class (big endian); the
// last of them produces a done word with type, class and the byte offset just
// past the question. A label length not below the available length sampled on
// the first byte, or a question running past the buffer size, produces one
// error word; bytes are then dropped until the next word marked first, which
// always restarts the parser. A byte produces zero or one result word.
// Throughput is one byte per clock: the per-byte step is a small state update
// between an input register and a result register, so a word can be taken
// every cycle while no stall is applied. An accepted byte waits in the input
// register, and its result word loads into the result register once that
// register is free. Either register holds its word while the far
// side stalls.
module dns_question_parser
  import dqp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [7:0]          data_byte,
  input  logic                first,
  input  logic [AVAIL_W-1:0]  avail_len,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [1:0]          kind,
  output logic [7:0]          name_char,
  output logic [15:0]         qtype,
  output logic [15:0]         qclass,
  output logic [OFFSET_W-1:0] end_offset
);

  item_t   item_in, held_item;
  logic    held_valid;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  result_t res, res_out;

  assign item_in.data_byte = data_byte;
  assign item_in.first     = first;
  assign item_in.avail_len = avail_len;

  // the held byte is processed once the result register can take its word
  assign advance = held_valid && out_free;

  dqp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // parser state advances only on a processed byte
  dqp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  dqp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (res_valid),
    .res_in       (res),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_out      (res_out)
  );

  assign kind       = res_out.kind;
  assign name_char  = res_out.name_char;
  assign qtype      = res_out.qtype;
  assign qclass     = res_out.qclass;
  assign end_offset = res_out.end_offset;

endmodule

@@ hdl/dqp_in_stage.sv @@
// input register for incoming question bytes
// depends on dqp_pkg
module dqp_in_stage
  import dqp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_stall,
  input  item_t item_in,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  // a held word leaves when advance is high, so a new one may enter then
  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held_item <= item_in;
    end
  end

endmodule

@@ hdl/dqp_parse.sv @@
// parser state and per-byte decode step
// depends on dqp_pkg
module dqp_parse
  import dqp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_LEN      = 3'd1,
    PH_LABEL    = 3'd2,
    PH_TYPE_HI  = 3'd3,
    PH_TYPE_LO  = 3'd4,
    PH_CLASS_HI = 3'd5,
    PH_CLASS_LO = 3'd6,
    PH_DRAIN    = 3'd7
  } phase_t;

  phase_t             phase, phase_next;
  logic [7:0]         label_left, label_left_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic               seen_label, seen_label_next;
  logic [AVAIL_W-1:0] avail_held, avail_held_next;
  logic [7:0]         high_byte, high_byte_next;
  logic [15:0]        type_held, type_held_next;

  always_comb begin
    phase_next      = phase;
    label_left_next = label_left;
    byte_count_next = byte_count;
    seen_label_next = seen_label;
    avail_held_next = avail_held;
    high_byte_next  = high_byte;
    type_held_next  = type_held;
    res_valid       = 1'b0;
    res             = '0;

    if (item.first) begin
      byte_count_next = '0;
      avail_held_next = item.avail_len;
      seen_label_next = 1'b0;
      label_left_next = '0;
      phase_next      = PH_LEN;
    end

    if (item.first || (phase != PH_IDLE && phase != PH_DRAIN)) begin
      if (byte_count_next >= CNT_W'(BUFFER_BYTES - 1)) begin
        // buffer overrun
        phase_next = PH_DRAIN;
        res_valid  = 1'b1;
        res.kind   = KIND_ERROR;
      end else begin
        byte_count_next = byte_count_next + 1'b1;
        unique case (phase_next)
          PH_LEN: begin
            if (item.data_byte == 8'd0) begin
              phase_next = PH_TYPE_HI;
            end else if (avail_held_next <= AVAIL_W'(item.data_byte)) begin
              phase_next = PH_DRAIN;
              res_valid  = 1'b1;
              res.kind   = KIND_ERROR;
            end else begin
              label_left_next = item.data_byte;
              phase_next      = PH_LABEL;
              seen_label_next = 1'b1;
              if (seen_label_next && !item.first && seen_label) begin
                res_valid     = 1'b1;
                res.kind      = KIND_CHAR;
                res.name_char = DOT_CHAR;
              end
            end
          end
          PH_LABEL: begin
            label_left_next = label_left - 1'b1;
            if (label_left_next == 8'd0) begin
              phase_next = PH_LEN;
            end
            res_valid     = 1'b1;
            res.kind      = KIND_CHAR;
            res.name_char = item.data_byte;
          end
          PH_TYPE_HI: begin
            high_byte_next = item.data_byte;
            phase_next     = PH_TYPE_LO;
          end
          PH_TYPE_LO: begin
            type_held_next = {high_byte, item.data_byte};
            phase_next     = PH_CLASS_HI;
          end
          PH_CLASS_HI: begin
            high_byte_next = item.data_byte;
            phase_next     = PH_CLASS_LO;
          end
          PH_CLASS_LO: begin
            phase_next     = PH_IDLE;
            res_valid      = 1'b1;
            res.kind       = KIND_DONE;
            res.qtype      = type_held;
            res.qclass     = {high_byte, item.data_byte};
            res.end_offset = OFFSET_W'(byte_count_next);
          end
          default: begin
          end
        endcase
      end
    end

    if (!go) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      label_left <= '0;
      byte_count <= '0;
      seen_label <= 1'b0;
      avail_held <= '0;
      high_byte  <= '0;
      type_held  <= '0;
    end else if (go) begin
      phase      <= phase_next;
      label_left <= label_left_next;
      byte_count <= byte_count_next;
      seen_label <= seen_label_next;
      avail_held <= avail_held_next;
      high_byte  <= high_byte_next;
      type_held  <= type_held_next;
    end
  end

endmodule

@@ hdl/dqp_out_stage.sv @@
// result register toward the downstream consumer
// depends on dqp_pkg
module dqp_out_stage
  import dqp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    free,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t res_out
);

  assign free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (free) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ tb/sv/tb_dns_question_parser.sv @@
// self-checking testbench for dns_question_parser
// depends on dqp_pkg and the hdl sources; drives byte words, checks result words
`timescale 1ns / 100ps

module tb_dns_question_parser;
  import dqp_pkg::*;

  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_ITEMS   = 1950;
  // quiet cycles allowed before the run is declared hung; the long
  // receiver hold-off is well below this
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_AT     = 700;
  // extra cycles waited at the end, once all result words have come back
  localparam int TAIL_CYCLES    = 10;
  localparam int MAX_REPORTS    = 50;
  localparam int CHUNK_ITEMS    = 300;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    Q_IDLE, Q_LEN, Q_LABEL, Q_TYPE_HI, Q_TYPE_LO, Q_CLASS_HI, Q_CLASS_LO, Q_DRAIN
  } parse_phase_t;

  // idling phases, chosen by how many byte words have been accepted
  typedef enum int {
    IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
  } idle_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [7:0]          data_byte = '0;
  logic                first = 1'b0;
  logic [AVAIL_W-1:0]  avail_len = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [1:0]          kind;
  logic [7:0]          name_char;
  logic [15:0]         qtype;
  logic [15:0]         qclass;
  logic [OFFSET_W-1:0] end_offset;

  dns_question_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .first        (first),
    .avail_len    (avail_len),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .name_char    (name_char),
    .qtype        (qtype),
    .qclass       (qclass),
    .end_offset   (end_offset)
  );

  always #HALF_PERIOD clk = ~clk;

  // byte words waiting to be driven, and result words still to come
  item_t   pending_bytes[$];
  result_t expected_words[$];

  int error_count    = 0;
  int accepted_bytes = 0;
  int quiet_cycles   = 0;
  int queued_bytes   = 0;
  // bytes left before a question is cut short; negative means no cut
  int cut_left       = -1;
  logic byte_taken   = 1'b0;

  // predictor copy of the parser state
  parse_phase_t       q_phase      = Q_IDLE;
  logic [7:0]         q_label_left = '0;
  int                 q_count      = 0;
  logic               q_seen_label = 1'b0;
  logic [AVAIL_W-1:0] q_avail      = '0;
  logic [7:0]         q_high       = '0;
  logic [15:0]        q_type       = '0;

  // hold-off state of the receiver
  int   holdoff_left = 0;
  logic holdoff_done = 1'b0;

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // one parser step for an accepted byte word; returns 1 when a result word is due
  function automatic bit decode_byte(input logic [7:0] b, input logic is_first,
                                     input logic [AVAIL_W-1:0] avail,
                                     output result_t word);
    word = '0;
    // a first byte restarts the question in any phase
    if (is_first) begin
      q_count      = 0;
      q_avail      = avail;
      q_seen_label = 1'b0;
      q_label_left = '0;
      q_phase      = Q_LEN;
    end else if (q_phase == Q_IDLE || q_phase == Q_DRAIN) begin
      return 1'b0;
    end
    // question longer than the buffer: error on the byte that would overflow
    if (q_count >= BUFFER_BYTES - 1) begin
      q_phase   = Q_DRAIN;
      word.kind = KIND_ERROR;
      return 1'b1;
    end
    q_count++;
    case (q_phase)
      Q_LEN: begin
        // zero length ends the name, root name included
        if (b == 8'd0) begin
          q_phase = Q_TYPE_HI;
          return 1'b0;
        end
        // label not shorter than the available length
        if (q_avail <= b) begin
          q_phase   = Q_DRAIN;
          word.kind = KIND_ERROR;
          return 1'b1;
        end
        q_label_left = b;
        q_phase      = Q_LABEL;
        if (q_seen_label) begin
          word.kind      = KIND_CHAR;
          word.name_char = DOT_CHAR;
          return 1'b1;
        end
        q_seen_label = 1'b1;
        return 1'b0;
      end
      Q_LABEL: begin
        q_label_left = q_label_left - 8'd1;
        if (q_label_left == 8'd0) q_phase = Q_LEN;
        word.kind      = KIND_CHAR;
        word.name_char = b;
        return 1'b1;
      end
      Q_TYPE_HI: begin
        q_high  = b;
        q_phase = Q_TYPE_LO;
        return 1'b0;
      end
      Q_TYPE_LO: begin
        q_type  = {q_high, b};
        q_phase = Q_CLASS_HI;
        return 1'b0;
      end
      Q_CLASS_HI: begin
        q_high  = b;
        q_phase = Q_CLASS_LO;
        return 1'b0;
      end
      Q_CLASS_LO: begin
        q_phase         = Q_IDLE;
        word.kind       = KIND_DONE;
        word.qtype      = q_type;
        word.qclass     = {q_high, b};
        word.end_offset = OFFSET_W'(q_count);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic idle_mode_t idle_mode();
    return idle_mode_t'((accepted_bytes / CHUNK_ITEMS) % 4);
  endfunction

  // ---------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------

  // queue one byte word, honoring a pending cut of the question
  task automatic push_byte(input logic [7:0] b, input logic f,
                           input logic [AVAIL_W-1:0] a);
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    pending_bytes.push_back(item_t'{data_byte: b, first: f, avail_len: a});
    queued_bytes++;
  endtask

  // a question with random content: labels, terminator, type and class;
  // avail_len on bytes not marked first is don't-care, so it gets noise
  task automatic add_question(input int n_labels, input int min_len,
                              input int max_len, input int avail);
    int len;
    for (int i = 0; i < n_labels; i++) begin
      len = $urandom_range(max_len, min_len);
      push_byte(8'(len), i == 0, (i == 0) ? AVAIL_W'(avail) : AVAIL_W'($urandom));
      for (int j = 0; j < len; j++) begin
        push_byte(8'($urandom), 1'b0, AVAIL_W'($urandom));
      end
    end
    push_byte(8'd0, n_labels == 0, (n_labels == 0) ? AVAIL_W'(avail) : AVAIL_W'($urandom));
    for (int k = 0; k < 4; k++) begin
      push_byte(8'($urandom), 1'b0, AVAIL_W'($urandom));
    end
  endtask

  // bytes that are not marked first; ignored when the parser is idle,
  // so they go straight into the queue without counting
  task automatic add_loose_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      pending_bytes.push_back(item_t'{data_byte: 8'($urandom), first: 1'b0,
                                      avail_len: AVAIL_W'($urandom)});
    end
  endtask

  initial begin
    int pick;
    int n_labels;
    int max_len;

    // ---- directed part ----
    // stray byte before any question is ignored
    push_byte(8'h41, 1'b0, 11'h7ff);
    // root name, type at its top value, class at zero
    push_byte(8'h00, 1'b1, 11'h000);
    push_byte(8'hff, 1'b0, 11'h000);
    push_byte(8'hff, 1'b0, 11'h000);
    push_byte(8'h00, 1'b0, 11'h000);
    push_byte(8'h00, 1'b0, 11'h000);
    // two labels with zero bytes copied through, avail at its top value
    push_byte(8'd2,  1'b1, 11'h7ff);
    push_byte(8'h00, 1'b0, 11'h000);
    push_byte(8'hff, 1'b0, 11'h000);
    push_byte(8'd1,  1'b0, 11'h000);
    push_byte("z",   1'b0, 11'h000);
    push_byte(8'h00, 1'b0, 11'h000);
    push_byte(8'h00, 1'b0, 11'h000);
    push_byte(8'h01, 1'b0, 11'h000);
    push_byte(8'hff, 1'b0, 11'h000);
    push_byte(8'hff, 1'b0, 11'h000);
    // label length equal to avail gives an error; next byte is ignored
    push_byte(8'd5,  1'b1, 11'd5);
    push_byte("a",   1'b0, 11'h000);
    // largest length against zero avail
    push_byte(8'hff, 1'b1, 11'd0);
    // first byte in the middle of a label restarts the question
    push_byte(8'd3,  1'b1, 11'd10);
    push_byte("a",   1'b0, 11'h000);
    push_byte("b",   1'b0, 11'h000);
    push_byte(8'd1,  1'b1, 11'd2);
    push_byte("x",   1'b0, 11'h000);
    push_byte(8'h00, 1'b0, 11'h000);
    push_byte(8'h12, 1'b0, 11'h000);
    push_byte(8'h34, 1'b0, 11'h000);
    push_byte(8'h56, 1'b0, 11'h000);
    push_byte(8'h78, 1'b0, 11'h000);
    // second label too long: error and no dot
    push_byte(8'd3,  1'b1, 11'd4);
    push_byte("a",   1'b0, 11'h000);
    push_byte("b",   1'b0, 11'h000);
    push_byte("c",   1'b0, 11'h000);
    push_byte(8'd4,  1'b0, 11'h000);

    // a question longer than the buffer ends in an error
    add_question(9, 250, 250, 2047);

    // ---- random part ----
    queued_bytes = 0;
    while (queued_bytes < RANDOM_ITEMS) begin
      pick     = $urandom_range(99);
      n_labels = $urandom_range(4, 0);
      // mostly short labels, now and then a long one
      max_len  = ($urandom_range(9) == 0) ? $urandom_range(255, 13) : $urandom_range(12, 1);
      if (pick < 60) begin
        add_question(n_labels, 1, max_len, $urandom_range(2047, max_len + 1));
      end else if (pick < 72) begin
        max_len = $urandom_range(12, 1);
        add_question($urandom_range(4, 1), 1, max_len, $urandom_range(max_len, 0));
      end else if (pick < 87) begin
        // cut short; the next question restarts the parser mid-way
        cut_left = $urandom_range(8, 1);
        add_question(n_labels, 1, max_len, $urandom_range(2047, max_len + 1));
        cut_left = -1;
      end else if (pick < 95) begin
        add_question(n_labels, 1, max_len, $urandom_range(2047, max_len + 1));
        add_loose_bytes($urandom_range(3, 1));
      end else begin
        add_loose_bytes($urandom_range(4, 1));
      end
    end

    // reset held, then released on a falling edge
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait until every byte is in and every result word has come back
    while (pending_bytes.size() != 0 || item_valid || expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // driver: byte words change on the falling edge
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    int idle_pct;
    item_t next_item;
    case (idle_mode())
      IDLE_SENDER: idle_pct = 57;
      IDLE_BOTH:   idle_pct = 9;
      default:     idle_pct = 0;
    endcase
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || byte_taken) begin
      // a held word only moves on once it has been taken
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_item  = pending_bytes.pop_front();
        data_byte  <= next_item.data_byte;
        first      <= next_item.first;
        avail_len  <= next_item.avail_len;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off so the block fills
  // up and pushes back on its input
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    int stall_pct;
    case (idle_mode())
      IDLE_RECEIVER: stall_pct = 57;
      IDLE_BOTH:     stall_pct = 9;
      default:       stall_pct = 0;
    endcase
    if (rst) begin
      result_stall <= 1'b0;
    end else if (!holdoff_done && accepted_bytes >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      result_stall <= 1'b1;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // monitor: on the rising edge, predict for each accepted byte word and
  // compare each accepted result word with the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    result_t got;
    bit      busy;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      busy = 1'b0;
      byte_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        busy = 1'b1;
        accepted_bytes++;
        if (decode_byte(data_byte, first, avail_len, want)) begin
          expected_words.push_back(want);
        end
      end
      if (result_valid && !result_stall) begin
        busy = 1'b1;
        got.kind       = kind_t'(kind);
        got.name_char  = name_char;
        got.qtype      = qtype;
        got.qclass     = qclass;
        got.end_offset = end_offset;
        if (expected_words.size() == 0) begin
          report_error($sformatf("result word with none expected: kind %0d char %02h",
                                 kind, name_char));
        end else begin
          want = expected_words.pop_front();
          if (got.kind != want.kind)
            report_error($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.name_char != want.name_char)
            report_error($sformatf("name_char %02h, expected %02h",
                                   got.name_char, want.name_char));
          if (got.qtype != want.qtype)
            report_error($sformatf("qtype %04h, expected %04h", got.qtype, want.qtype));
          if (got.qclass != want.qclass)
            report_error($sformatf("qclass %04h, expected %04h", got.qclass, want.qclass));
          if (got.end_offset != want.end_offset)
            report_error($sformatf("end_offset %0d, expected %0d",
                                   got.end_offset, want.end_offset));
        end
      end
      // watchdog on cycles where no word moves on either side
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

@@ dns_question_parser.f @@
hdl/dqp_pkg.sv
hdl/dqp_in_stage.sv
hdl/dqp_parse.sv
hdl/dqp_out_stage.sv
hdl/dns_question_parser.sv
tb/sv/tb_dns_question_parser.sv
